>>> rtl/gvc_pkg.sv
// Shared constants, codes and controller/datapath interface types for the vertex cover engine.
`timescale 1ns / 1ps
`default_nettype none

package gvc_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int VW           = $clog2(MAX_VERTICES);
    localparam int MAX_EDGES    = 64;
    localparam int EIW          = $clog2(MAX_EDGES);
    localparam int ECW          = $clog2(MAX_EDGES + 1);
    localparam int EDGE_W       = 2 * VW;
    localparam int VCW          = 6;
    localparam int SIZE_W       = 6;
    localparam int SEED_W       = 16;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;

    localparam logic [SEED_W-1:0] LFSR_TAPS    = 16'hB400;
    localparam logic [VCW-1:0]    VCOUNT_RESET = 6'd32;
    localparam logic [SEED_W-1:0] SEED_RESET   = 16'd1;

    // Register indexes, taken from paddr[2].
    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_TIE_SEED     = 1'b1;

    typedef enum logic [1:0] {
        ST_STORED = 2'd0,
        ST_RANGE  = 2'd1,
        ST_FULL   = 2'd2,
        ST_DONE   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_FIRST_W,
        S_COUNT,
        S_DECIDE,
        S_MARK,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic store_edge;
        logic run_start;
        logic walk;
        logic walk_init;
        logic cap_first;
        logic count_en;
        logic decide;
        logic mark_en;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic walk_end;
        logic found;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> rtl/gvc_dp.sv
// Datapath: edge store, covered flags, degree counters, tie LFSR and result registers.
`timescale 1ns / 1ps
`default_nettype none

module gvc_dp (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire gvc_pkg::t_dp_cmd          i_cmd,
    input  wire logic [gvc_pkg::VW-1:0]    i_vertex_u,
    input  wire logic [gvc_pkg::VW-1:0]    i_vertex_v,
    input  wire logic [gvc_pkg::VCW-1:0]   i_limit,
    input  wire logic [gvc_pkg::SEED_W-1:0] i_seed,
    output gvc_pkg::t_dp_stat              o_stat,
    output logic                           o_result_valid,
    output logic [1:0]                     o_status,
    output logic [gvc_pkg::MAX_VERTICES-1:0] o_cover_mask,
    output logic [gvc_pkg::SIZE_W-1:0]     o_cover_size,
    output logic [gvc_pkg::ECW-1:0]        o_edge_count
);
    import gvc_pkg::*;

    // The top bit of each entry is its covered flag. An add writes it clear, so a new run
    // needs no clearing pass over the store.
    logic [EDGE_W:0]         r_edge_mem [MAX_EDGES];
    logic [EDGE_W:0]         r_rd_data;
    logic [ECW-1:0]          r_stored;
    logic [ECW-1:0]          r_idx;
    logic                    r_pipe_vld;
    logic [EIW-1:0]          r_pipe_idx;
    logic [VW-1:0]           r_u;
    logic [VW-1:0]           r_v;
    logic [VW-1:0]           r_sel;
    logic [ECW-1:0]          r_du;
    logic [ECW-1:0]          r_dv;
    logic                    r_found;
    logic [MAX_VERTICES-1:0] r_cover;
    logic [SIZE_W-1:0]       r_cover_size;
    logic [SEED_W-1:0]       r_lfsr;
    logic                    r_res_valid;
    t_status                 r_res_status;
    logic [MAX_VERTICES-1:0] r_res_mask;
    logic [SIZE_W-1:0]       r_res_size;
    logic [ECW-1:0]          r_res_count;

    logic              in_range;
    logic              full;
    logic              add_ok;
    logic              rd_en;
    logic              mark_wr;
    logic [VW-1:0]     pipe_u;
    logic [VW-1:0]     pipe_v;
    logic              pipe_live;
    logic              touch_u;
    logic              touch_v;
    logic              touch_s;
    logic [SEED_W-1:0] lfsr_nx;
    logic              tie;
    logic              pick_u;
    logic [VW-1:0]     sel_nx;

    assign in_range = ({1'b0, i_vertex_u} < i_limit) && ({1'b0, i_vertex_v} < i_limit);
    assign full     = (r_stored == ECW'(MAX_EDGES));
    assign add_ok   = i_cmd.store_edge && in_range && !full;
    assign rd_en    = i_cmd.walk && (r_idx != r_stored);

    assign pipe_u    = r_rd_data[VW-1:0];
    assign pipe_v    = r_rd_data[EDGE_W-1:VW];
    assign pipe_live = r_pipe_vld && !r_rd_data[EDGE_W];
    assign touch_u   = (pipe_u == r_u) || (pipe_v == r_u);
    assign touch_v   = (pipe_u == r_v) || (pipe_v == r_v);
    assign touch_s   = (pipe_u == r_sel) || (pipe_v == r_sel);
    assign mark_wr   = i_cmd.mark_en && pipe_live && touch_s;

    assign lfsr_nx = {1'b0, r_lfsr[SEED_W-1:1]} ^ (r_lfsr[0] ? LFSR_TAPS : '0);
    assign tie     = (r_du == r_dv);
    assign pick_u  = tie ? lfsr_nx[0] : (r_du > r_dv);
    assign sel_nx  = pick_u ? r_u : r_v;

    assign o_stat.empty    = (r_stored == '0);
    assign o_stat.walk_end = (r_idx == r_stored) && !r_pipe_vld;
    assign o_stat.found    = r_found;

    assign o_result_valid = r_res_valid;
    assign o_status       = r_res_status;
    assign o_cover_mask   = r_res_mask;
    assign o_cover_size   = r_res_size;
    assign o_edge_count   = r_res_count;

    always_ff @(posedge i_clk) begin
        if (add_ok) begin
            r_edge_mem[r_stored[EIW-1:0]] <= {1'b0, i_vertex_v, i_vertex_u};
        end else if (mark_wr) begin
            r_edge_mem[r_pipe_idx] <= {1'b1, r_rd_data[EDGE_W-1:0]};
        end
        if (rd_en) begin
            r_rd_data <= r_edge_mem[r_idx[EIW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored     <= '0;
            r_idx        <= '0;
            r_pipe_vld   <= 1'b0;
            r_pipe_idx   <= '0;
            r_u          <= '0;
            r_v          <= '0;
            r_sel        <= '0;
            r_du         <= '0;
            r_dv         <= '0;
            r_found      <= 1'b0;
            r_cover      <= '0;
            r_cover_size <= '0;
            r_lfsr       <= SEED_W'(1);
            r_res_valid  <= 1'b0;
            r_res_status <= ST_STORED;
            r_res_mask   <= '0;
            r_res_size   <= '0;
            r_res_count  <= '0;
        end else begin
            r_res_valid <= 1'b0;
            r_pipe_vld  <= rd_en;
            if (rd_en) begin
                r_pipe_idx <= r_idx[EIW-1:0];
                r_idx      <= r_idx + ECW'(1);
            end
            if (i_cmd.walk_init) begin
                r_idx   <= '0;
                r_du    <= '0;
                r_dv    <= '0;
                r_found <= 1'b0;
            end

            if (i_cmd.store_edge) begin
                r_res_valid <= 1'b1;
                r_res_mask  <= '0;
                r_res_size  <= '0;
                if (!in_range) begin
                    r_res_status <= ST_RANGE;
                    r_res_count  <= r_stored;
                end else if (full) begin
                    r_res_status <= ST_FULL;
                    r_res_count  <= r_stored;
                end else begin
                    r_res_status <= ST_STORED;
                    r_res_count  <= r_stored + ECW'(1);
                    r_stored     <= r_stored + ECW'(1);
                end
            end

            if (i_cmd.run_start) begin
                r_cover      <= '0;
                r_cover_size <= '0;
                r_lfsr       <= (i_seed != '0) ? i_seed : SEED_W'(1);
                r_idx        <= '0;
                r_found      <= 1'b0;
            end

            if (i_cmd.cap_first) begin
                r_u <= pipe_u;
                r_v <= pipe_v;
            end

            if (i_cmd.count_en && pipe_live) begin
                r_du <= r_du + ECW'(touch_u);
                r_dv <= r_dv + ECW'(touch_v);
            end

            if (i_cmd.decide) begin
                if (tie) begin
                    r_lfsr <= lfsr_nx;
                end
                r_sel          <= sel_nx;
                r_cover[sel_nx] <= 1'b1;
                if (!r_cover[sel_nx]) begin
                    r_cover_size <= r_cover_size + SIZE_W'(1);
                end
            end

            // The first edge left uncovered by this sweep becomes the next pass's pivot.
            if (i_cmd.mark_en && pipe_live && !touch_s && !r_found) begin
                r_found <= 1'b1;
                r_u     <= pipe_u;
                r_v     <= pipe_v;
            end

            if (i_cmd.finish) begin
                r_stored     <= '0;
                r_res_valid  <= 1'b1;
                r_res_status <= ST_DONE;
                r_res_mask   <= r_cover;
                r_res_size   <= r_cover_size;
                r_res_count  <= '0;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/gvc_ctrl.sv
// Controller state machine that sequences edge loads and the greedy cover passes.
`timescale 1ns / 1ps
`default_nettype none

module gvc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_operation,
    input  wire gvc_pkg::t_dp_stat i_stat,
    output gvc_pkg::t_dp_cmd       o_cmd,
    output logic                   o_busy
);
    import gvc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (!i_operation) begin
                        o_cmd.store_edge = 1'b1;
                    end else begin
                        o_cmd.run_start = 1'b1;
                        n_state = i_stat.empty ? S_FINISH : S_FIRST;
                    end
                end
            end
            S_FIRST: begin
                o_cmd.walk = 1'b1;
                n_state    = S_FIRST_W;
            end
            S_FIRST_W: begin
                o_cmd.cap_first = 1'b1;
                o_cmd.walk_init = 1'b1;
                n_state         = S_COUNT;
            end
            S_COUNT: begin
                o_cmd.walk     = 1'b1;
                o_cmd.count_en = 1'b1;
                if (i_stat.walk_end) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide    = 1'b1;
                o_cmd.walk_init = 1'b1;
                n_state         = S_MARK;
            end
            S_MARK: begin
                o_cmd.walk    = 1'b1;
                o_cmd.mark_en = 1'b1;
                if (i_stat.walk_end) begin
                    if (i_stat.found) begin
                        o_cmd.walk_init = 1'b1;
                        n_state         = S_COUNT;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/greedy_vertex_cover.sv
// Top level of the greedy vertex cover engine: APB registers, controller and datapath.
// An add-edge transaction is accepted while idle; busy stays low, so adds run one per cycle
// and each result is strobed the cycle after acceptance.
// A compute transaction keeps busy high through up to n cover passes (n stored edges), or
// only through the finish step for an empty store; each pass is two sweeps over the edge
// store through its single read port. The result is strobed in the cycle busy falls.
// Results cannot be stalled. Synchronous active-low reset clears the store, sets
// vertex_count to 32 and tie_seed to 1.
`timescale 1ns / 1ps
`default_nettype none

module greedy_vertex_cover (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [gvc_pkg::APB_AW-1:0]    paddr,
    input  wire logic [gvc_pkg::APB_DW-1:0]    pwdata,
    output logic [gvc_pkg::APB_DW-1:0]         prdata,
    output logic                               pready,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_operation,
    input  wire logic [gvc_pkg::VW-1:0]        i_vertex_u,
    input  wire logic [gvc_pkg::VW-1:0]        i_vertex_v,
    output logic                               o_result_valid,
    output logic [1:0]                         o_status,
    output logic [gvc_pkg::MAX_VERTICES-1:0]   o_cover_mask,
    output logic [gvc_pkg::SIZE_W-1:0]         o_cover_size,
    output logic [gvc_pkg::ECW-1:0]            o_edge_count
);
    import gvc_pkg::*;

    logic [VCW-1:0]    r_vertex_count;
    logic [SEED_W-1:0] r_tie_seed;
    logic              cfg_wr;
    logic [VCW-1:0]    limit;
    t_dp_cmd           cmd;
    t_dp_stat          stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VCOUNT_RESET;
            r_tie_seed     <= SEED_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_VERTEX_COUNT: r_vertex_count <= pwdata[VCW-1:0];
                REG_TIE_SEED:     r_tie_seed     <= pwdata[SEED_W-1:0];
                default:          r_tie_seed     <= r_tie_seed;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_VERTEX_COUNT: prdata = {{(APB_DW-VCW){1'b0}}, r_vertex_count};
            REG_TIE_SEED:     prdata = {{(APB_DW-SEED_W){1'b0}}, r_tie_seed};
            default:          prdata = '0;
        endcase
    end

    // Counts above the vertex capacity behave as the capacity.
    assign limit = (r_vertex_count > VCW'(MAX_VERTICES)) ? VCW'(MAX_VERTICES) : r_vertex_count;

    gvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (busy)
    );

    gvc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_vertex_u     (i_vertex_u),
        .i_vertex_v     (i_vertex_v),
        .i_limit        (limit),
        .i_seed         (r_tie_seed),
        .o_stat         (stat),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_cover_mask   (o_cover_mask),
        .o_cover_size   (o_cover_size),
        .o_edge_count   (o_edge_count)
    );

    // Busy only rises after a compute transaction was taken.
    a_busy_from_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && i_operation))
        else $error("busy rose without a compute transaction");

    // A cover result appears exactly as the engine goes idle.
    a_done_on_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status == ST_DONE)) |-> $fell(busy))
        else $error("cover result without end of run");

    // An accepted add gets a non-cover result in the next cycle.
    a_add_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_operation) |=> (o_result_valid && (o_status != ST_DONE)))
        else $error("add transaction produced no edge result");

endmodule

`default_nettype wire
